// ===== rtl/fvct_pkg.sv =====
package fvct_pkg;

	localparam int MODE_W   = 2;
	localparam int NODE_W   = 10;
	localparam int BLOCK_W  = 2;
	localparam int WEIGHT_W = 16;
	localparam int AFF_W    = 3;
	localparam int ACC_W    = 26;
	localparam int COUNT_W  = 11;

	// Number of limit registers; the pin code one past the last block means unpinned.
	localparam int                MAX_BLOCKS = 4;
	localparam logic [AFF_W-1:0]  BLK_NONE   = 3'd4;

	typedef enum logic [MODE_W-1:0] {
		MODE_FIX         = 2'd0,
		MODE_CONTRACT    = 2'd1,
		MODE_CONTRACT_NC = 2'd2,
		MODE_UNCONTRACT  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [AFF_W-1:0]    pin;
		logic [COUNT_W-1:0]  cnt;
		logic [WEIGHT_W-1:0] wt;
	} node_entry_t;

endpackage

// ===== rtl/fvct_in_if.sv =====
interface fvct_in_if;
	import fvct_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [NODE_W-1:0]   node_u;
	logic [NODE_W-1:0]   node_v;
	logic [BLOCK_W-1:0]  target_block;
	logic [WEIGHT_W-1:0] weight_u;
	logic [WEIGHT_W-1:0] weight_v;

	modport source (
		output valid, mode, node_u, node_v, target_block, weight_u, weight_v,
		input  ready
	);

	modport sink (
		input  valid, mode, node_u, node_v, target_block, weight_u, weight_v,
		output ready
	);

endinterface

// ===== rtl/fvct_out_if.sv =====
interface fvct_out_if;
	import fvct_pkg::*;

	logic             valid;
	logic             ready;
	logic             success;
	logic [AFF_W-1:0] affected_block;
	logic [ACC_W-1:0] block_fixed_weight;
	logic [ACC_W-1:0] total_fixed_weight;

	modport source (
		output valid, success, affected_block, block_fixed_weight, total_fixed_weight,
		input  ready
	);

	modport sink (
		input  valid, success, affected_block, block_fixed_weight, total_fixed_weight,
		output ready
	);

endinterface

// ===== rtl/fixed_vertex_contraction_tracker.sv =====
// Channel   | Role   | Handshake     | Carries
// ----------+--------+---------------+---------------------------------------------------
// items     | sink   | valid / ready | mode, node_u, node_v, target_block, weights
// results   | source | valid / ready | success, affected_block, block and total weight
// cfg       | write  | cfg_we        | cfg_idx selects limit_block0..3, cfg_wdata value
//
// For each item, the accepting edge reads both node entries, the check cycle decides
// and updates the block weight, and the total cycle updates the total and loads the
// result register. One 27-bit adder/subtractor serves both weight updates.
// After reset a clearing pass marks every node unpinned; items are not taken
// meanwhile, configuration writes are. A stalled result holds the total cycle until
// the result register is free, so the next item waits behind it.
module fixed_vertex_contraction_tracker #(
	parameter int TABLE_DEPTH = 1024,
	parameter int NUM_BLOCKS  = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_idx,
	input  logic [fvct_pkg::ACC_W-1:0]  cfg_wdata,
	fvct_in_if.sink                     items,
	fvct_out_if.source                  results
);
	import fvct_pkg::*;

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int BW  = $clog2(NUM_BLOCKS);
	localparam int IXW = 17;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_CHK   = 4'b0100,
		ST_TOT   = 4'b1000
	} state_t;

	state_t state_q;

	// Node table: one entry per node, two registered read ports, one write port.
	node_entry_t mem [TABLE_DEPTH];
	node_entry_t rd_u_q, rd_v_q;
	logic        mem_we;
	logic [AW-1:0] mem_wa;
	node_entry_t mem_wd;
	logic [AW-1:0] clr_cnt_q;

	// Item registers.
	mode_t               mode_q;
	logic [BLOCK_W-1:0]  tb_q;
	logic [WEIGHT_W-1:0] wu_q, wv_q;
	logic                u_ok_q, v_ok_q;
	logic [AW-1:0]       ua_q, va_q;

	// Configuration and accumulators.
	logic [ACC_W-1:0] limit_q [MAX_BLOCKS];
	logic [ACC_W-1:0] bw_q [NUM_BLOCKS];
	logic [ACC_W-1:0] total_q;

	// Decision carried from the check cycle to the total cycle.
	logic                ok_q;
	logic [AFF_W-1:0]    aff_q;
	logic                upd_q;
	logic                sub_q;
	logic [WEIGHT_W-1:0] delta_q;

	// Result register.
	logic             out_vld_q;
	logic             out_ok_q;
	logic [AFF_W-1:0] out_aff_q;
	logic [ACC_W-1:0] out_bw_q;
	logic [ACC_W-1:0] out_tot_q;

	logic accept;
	logic tot_done;
	logic [IXW-1:0] u_ext, v_ext;

	assign accept   = items.valid && items.ready;
	assign tot_done = (state_q == ST_TOT) && (!out_vld_q || results.ready);
	assign u_ext    = IXW'(items.node_u);
	assign v_ext    = IXW'(items.node_v);

	assign items.ready = (state_q == ST_IDLE);

	// Decision logic of the check cycle.
	logic                pu, pv;
	logic                ok_n, chk_n, upd_n, sub_n, we_n;
	logic                ok_f, upd_f, we_f;
	logic [AFF_W-1:0]    aff_n;
	logic [WEIGHT_W-1:0] delta_n;
	logic [AW-1:0]       wa_n;
	node_entry_t         wr_n;
	logic [COUNT_W-1:0]  cnt_dec;
	logic                fits;

	// Shared adder/subtractor.
	logic [ACC_W-1:0]    add_a;
	logic [WEIGHT_W-1:0] add_b;
	logic                add_sub;
	logic [ACC_W:0]      add_sum;

	assign pu      = rd_u_q.pin < AFF_W'(NUM_BLOCKS);
	assign pv      = rd_v_q.pin < AFF_W'(NUM_BLOCKS);
	assign cnt_dec = rd_u_q.cnt - COUNT_W'(1);

	always_comb begin
		ok_n    = 1'b0;
		chk_n   = 1'b0;
		upd_n   = 1'b0;
		sub_n   = 1'b0;
		we_n    = 1'b0;
		aff_n   = BLK_NONE;
		delta_n = wu_q;
		wa_n    = ua_q;
		wr_n    = rd_u_q;
		unique case (mode_q) inside
			MODE_FIX: begin
				if (u_ok_q && (AFF_W'(tb_q) < AFF_W'(NUM_BLOCKS))) begin
					aff_n = AFF_W'(tb_q);
					if (!pu) begin
						ok_n  = 1'b1;
						we_n  = 1'b1;
						upd_n = 1'b1;
						wr_n  = '{pin: AFF_W'(tb_q), cnt: COUNT_W'(1), wt: wu_q};
					end else begin
						ok_n = (rd_u_q.pin == AFF_W'(tb_q));
					end
				end
			end
			MODE_CONTRACT, MODE_CONTRACT_NC: begin
				if (u_ok_q && v_ok_q) begin
					ok_n = 1'b1;
					if (pu && pv) begin
						if (rd_u_q.pin == rd_v_q.pin) begin
							aff_n      = rd_u_q.pin;
							we_n       = 1'b1;
							wr_n.cnt   = rd_u_q.cnt + COUNT_W'(1);
						end else begin
							ok_n = 1'b0;
						end
					end else if (pu || pv) begin
						aff_n   = pv ? rd_v_q.pin : rd_u_q.pin;
						delta_n = pv ? wu_q : wv_q;
						chk_n   = 1'b1;
						upd_n   = 1'b1;
						if (pv) begin
							we_n = 1'b1;
							wr_n = '{pin: rd_v_q.pin, cnt: COUNT_W'(1), wt: wu_q};
						end else if (mode_q == MODE_CONTRACT) begin
							// The pin spreads to node_v only when chains are recorded.
							we_n = 1'b1;
							wa_n = va_q;
							wr_n = '{pin: rd_u_q.pin, cnt: rd_v_q.cnt, wt: wv_q};
						end
					end
				end
			end
			MODE_UNCONTRACT: begin
				if (u_ok_q && v_ok_q) begin
					ok_n = 1'b1;
					if (pv) begin
						if (rd_v_q.cnt != '0) begin
							we_n     = 1'b1;
							wr_n.cnt = cnt_dec;
							if (cnt_dec == '0 && pu) begin
								aff_n    = rd_u_q.pin;
								sub_n    = 1'b1;
								upd_n    = 1'b1;
								delta_n  = rd_u_q.wt;
								wr_n.pin = BLK_NONE;
							end
						end else begin
							aff_n   = rd_v_q.pin;
							sub_n   = 1'b1;
							upd_n   = 1'b1;
							delta_n = rd_v_q.wt;
							we_n    = 1'b1;
							wa_n    = va_q;
							wr_n    = '{pin: BLK_NONE, cnt: rd_v_q.cnt, wt: rd_v_q.wt};
						end
					end
				end
			end
			default: begin
				ok_n = 1'b0;
			end
		endcase
	end

	// The adder works on the affected block in the check cycle and on the total after.
	always_comb begin
		if (state_q == ST_CHK) begin
			add_a   = bw_q[aff_n[BW-1:0]];
			add_b   = delta_n;
			add_sub = sub_n;
		end else begin
			add_a   = total_q;
			add_b   = delta_q;
			add_sub = sub_q;
		end
		if (add_sub) begin
			add_sum = {1'b0, add_a} - (ACC_W+1)'(add_b);
		end else begin
			add_sum = {1'b0, add_a} + (ACC_W+1)'(add_b);
		end
	end

	// The limit compare uses the unwrapped sum.
	assign fits  = add_sum <= {1'b0, limit_q[aff_n[BLOCK_W-1:0]]};
	assign ok_f  = ok_n && (!chk_n || fits);
	assign upd_f = upd_n && (!chk_n || fits);
	assign we_f  = we_n && (!chk_n || fits);

	// Write port: clearing pass after reset, else the check cycle's write-back.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
			mem_wd = '{pin: BLK_NONE, cnt: '0, wt: '0};
		end else begin
			mem_we = (state_q == ST_CHK) && we_f;
			mem_wa = wa_n;
			mem_wd = wr_n;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (accept) begin
			rd_u_q <= mem[u_ext[AW-1:0]];
			rd_v_q <= mem[v_ext[AW-1:0]];
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(items.mode);
			tb_q   <= items.target_block;
			wu_q   <= items.weight_u;
			wv_q   <= items.weight_v;
			u_ok_q <= u_ext < IXW'(TABLE_DEPTH);
			v_ok_q <= v_ext < IXW'(TABLE_DEPTH);
			ua_q   <= u_ext[AW-1:0];
			va_q   <= v_ext[AW-1:0];
		end
		if (state_q == ST_CHK) begin
			ok_q    <= ok_f;
			aff_q   <= aff_n;
			upd_q   <= upd_f;
			sub_q   <= sub_n;
			delta_q <= delta_n;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					state_q <= ST_TOT;
				end
				ST_TOT: begin
					if (tot_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Limits and weight accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				limit_q[i] <= '1;
			end
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				bw_q[i] <= '0;
			end
			total_q <= '0;
		end else begin
			if (cfg_we) begin
				limit_q[cfg_idx] <= cfg_wdata;
			end
			if ((state_q == ST_CHK) && upd_f) begin
				bw_q[aff_n[BW-1:0]] <= add_sum[ACC_W-1:0];
			end
			if (tot_done && upd_q) begin
				total_q <= add_sum[ACC_W-1:0];
			end
		end
	end

	// Result register: valid under reset, payload loaded when the total is settled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (tot_done) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tot_done) begin
			out_ok_q  <= ok_q;
			out_aff_q <= aff_q;
			out_bw_q  <= (aff_q == BLK_NONE) ? '0 : bw_q[aff_q[BW-1:0]];
			out_tot_q <= upd_q ? add_sum[ACC_W-1:0] : total_q;
		end
	end

	assign results.valid              = out_vld_q;
	assign results.success            = out_ok_q;
	assign results.affected_block     = out_aff_q;
	assign results.block_fixed_weight = out_bw_q;
	assign results.total_fixed_weight = out_tot_q;

endmodule

// ===== tb/fvct_tb_pkg.sv =====
package fvct_tb_pkg;
	import fvct_pkg::*;

	localparam int NODE_COUNT = 1 << NODE_W;

	typedef struct packed {
		mode_t               mode;
		logic [NODE_W-1:0]   node_u;
		logic [NODE_W-1:0]   node_v;
		logic [BLOCK_W-1:0]  target_block;
		logic [WEIGHT_W-1:0] weight_u;
		logic [WEIGHT_W-1:0] weight_v;
	} pin_request_t;

	typedef struct packed {
		logic             success;
		logic [AFF_W-1:0] affected_block;
		logic [ACC_W-1:0] block_fixed_weight;
		logic [ACC_W-1:0] total_fixed_weight;
	} step_outcome_t;

	// Mirrors the node table and the block weights, and queues the outcome that each
	// accepted request must produce.
	class pin_weight_scoreboard;
		logic [AFF_W-1:0]    pin_of    [NODE_COUNT];
		logic [COUNT_W-1:0]  merges_of [NODE_COUNT];
		logic [WEIGHT_W-1:0] pinned_wt [NODE_COUNT];
		logic [ACC_W-1:0]    block_wt  [MAX_BLOCKS];
		logic [ACC_W-1:0]    limit_wt  [MAX_BLOCKS];
		logic [ACC_W-1:0]    total_wt;
		step_outcome_t       awaited_outcomes [$];
		int                  failures;

		function new();
			foreach (pin_of[i]) begin
				pin_of[i]    = BLK_NONE;
				merges_of[i] = '0;
				pinned_wt[i] = '0;
			end
			foreach (block_wt[b]) begin
				block_wt[b] = '0;
				limit_wt[b] = '1;
			end
			total_wt = '0;
			failures = 0;
		endfunction

		function void set_limit(int idx, logic [ACC_W-1:0] value);
			limit_wt[idx] = value;
		endfunction

		function bit is_pinned(logic [NODE_W-1:0] n);
			return pin_of[n] < AFF_W'(MAX_BLOCKS);
		endfunction

		function void shift_weight(logic [AFF_W-1:0] blk, logic [WEIGHT_W-1:0] w, bit remove);
			if (remove) begin
				block_wt[blk] = block_wt[blk] - ACC_W'(w);
				total_wt      = total_wt - ACC_W'(w);
			end else begin
				block_wt[blk] = block_wt[blk] + ACC_W'(w);
				total_wt      = total_wt + ACC_W'(w);
			end
		endfunction

		function void note_request(pin_request_t rq);
			step_outcome_t       outcome;
			logic [AFF_W-1:0]    blk;
			logic [WEIGHT_W-1:0] delta;
			logic [ACC_W:0]      grown;
			logic [COUNT_W-1:0]  left;
			bit                  pu;
			bit                  pv;
			pu = is_pinned(rq.node_u);
			pv = is_pinned(rq.node_v);
			outcome.success        = 1'b0;
			outcome.affected_block = BLK_NONE;
			case (rq.mode)
				MODE_FIX: begin
					outcome.affected_block = AFF_W'(rq.target_block);
					if (!pu) begin
						pin_of[rq.node_u]    = AFF_W'(rq.target_block);
						merges_of[rq.node_u] = COUNT_W'(1);
						pinned_wt[rq.node_u] = rq.weight_u;
						shift_weight(AFF_W'(rq.target_block), rq.weight_u, 1'b0);
						outcome.success = 1'b1;
					end else begin
						outcome.success = (pin_of[rq.node_u] == AFF_W'(rq.target_block));
					end
				end
				MODE_CONTRACT, MODE_CONTRACT_NC: begin
					outcome.success = 1'b1;
					if (pu && pv) begin
						if (pin_of[rq.node_u] == pin_of[rq.node_v]) begin
							outcome.affected_block = pin_of[rq.node_u];
							merges_of[rq.node_u]   = merges_of[rq.node_u] + COUNT_W'(1);
						end else begin
							outcome.success = 1'b0;
						end
					end else if (pu || pv) begin
						blk   = pv ? pin_of[rq.node_v] : pin_of[rq.node_u];
						delta = pv ? rq.weight_u : rq.weight_v;
						outcome.affected_block = blk;
						grown = {1'b0, block_wt[blk]} + (ACC_W+1)'(delta);
						if (grown <= {1'b0, limit_wt[blk]}) begin
							shift_weight(blk, delta, 1'b0);
							if (pv) begin
								pin_of[rq.node_u]    = blk;
								merges_of[rq.node_u] = COUNT_W'(1);
								pinned_wt[rq.node_u] = rq.weight_u;
							end else if (rq.mode == MODE_CONTRACT) begin
								pin_of[rq.node_v]    = blk;
								pinned_wt[rq.node_v] = rq.weight_v;
							end
						end else begin
							outcome.success = 1'b0;
						end
					end
				end
				default: begin
					outcome.success = 1'b1;
					if (pv) begin
						if (merges_of[rq.node_v] != '0) begin
							left = merges_of[rq.node_u] - COUNT_W'(1);
							merges_of[rq.node_u] = left;
							if (left == '0 && pu) begin
								outcome.affected_block = pin_of[rq.node_u];
								shift_weight(pin_of[rq.node_u], pinned_wt[rq.node_u], 1'b1);
								pin_of[rq.node_u] = BLK_NONE;
							end
						end else begin
							outcome.affected_block = pin_of[rq.node_v];
							shift_weight(pin_of[rq.node_v], pinned_wt[rq.node_v], 1'b1);
							pin_of[rq.node_v] = BLK_NONE;
						end
					end
				end
			endcase
			outcome.block_fixed_weight = (outcome.affected_block < AFF_W'(MAX_BLOCKS)) ?
				block_wt[outcome.affected_block] : '0;
			outcome.total_fixed_weight = total_wt;
			awaited_outcomes.push_back(outcome);
		endfunction

		function void match_field(string what, logic [ACC_W-1:0] want, logic [ACC_W-1:0] seen);
			if (seen !== want) begin
				$display("%0t: %s expected %0d, actual %0d", $time, what, want, seen);
				failures++;
			end
		endfunction

		function void check_result(step_outcome_t got);
			step_outcome_t want;
			if (awaited_outcomes.size() == 0) begin
				$display("%0t: result with nothing outstanding, actual success %0d block %0d",
					$time, got.success, got.affected_block);
				failures++;
				return;
			end
			want = awaited_outcomes.pop_front();
			match_field("success", ACC_W'(want.success), ACC_W'(got.success));
			match_field("affected_block", ACC_W'(want.affected_block),
				ACC_W'(got.affected_block));
			match_field("block_fixed_weight", want.block_fixed_weight, got.block_fixed_weight);
			match_field("total_fixed_weight", want.total_fixed_weight, got.total_fixed_weight);
		endfunction
	endclass

endpackage

// ===== tb/tb_fixed_vertex_contraction_tracker.sv =====
module tb_fixed_vertex_contraction_tracker;
	import fvct_pkg::*;
	import fvct_tb_pkg::*;

	localparam int               HALF_PERIOD   = 5;
	localparam int               RESET_CYCLES  = 6;
	localparam int               SETTLE_CYCLES = 20;
	localparam int               HOLD_CYCLES   = 200;
	localparam int               PHASE_ITEMS   = 225;
	localparam int               PHASE_COUNT   = 4;
	localparam int               POOL_SPAN     = 24;
	localparam logic [ACC_W-1:0] LIMIT_MAX     = '1;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_idx;
	logic [ACC_W-1:0] cfg_wdata;

	fvct_in_if  items_ch ();
	fvct_out_if results_ch ();

	fixed_vertex_contraction_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.items     (items_ch),
		.results   (results_ch)
	);

	pin_weight_scoreboard board;

	// While no_idle is set, neither side inserts gaps. stall_request asks the result
	// side for one long hold-off; it clears the flag itself once it starts.
	bit no_idle;
	bit stall_request;

	// Random stimulus works on a small window of nodes so that fixes, merges and
	// undos keep meeting each other. Merges are logged so that most undos reverse
	// a merge that was actually requested, newest first.
	int                  pool_base;
	logic [2*NODE_W-1:0] merge_log [$];

	always #HALF_PERIOD clk = ~clk;

	// Offers one request and returns once it has been transferred. All signals are
	// sampled right after the edge, so they still hold the values from before it.
	task automatic send_request(pin_request_t rq);
		if (!no_idle && $urandom_range(99) < 15) begin
			items_ch.valid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		items_ch.valid        <= 1'b1;
		items_ch.mode         <= rq.mode;
		items_ch.node_u       <= rq.node_u;
		items_ch.node_v       <= rq.node_v;
		items_ch.target_block <= rq.target_block;
		items_ch.weight_u     <= rq.weight_u;
		items_ch.weight_v     <= rq.weight_v;
		@(posedge clk);
		while (items_ch.ready !== 1'b1) @(posedge clk);
		board.note_request(rq);
	endtask

	task automatic issue(mode_t m, int u, int v, int blk, int wu, int wv);
		pin_request_t rq;
		rq.mode         = m;
		rq.node_u       = NODE_W'(u);
		rq.node_v       = NODE_W'(v);
		rq.target_block = BLOCK_W'(blk);
		rq.weight_u     = WEIGHT_W'(wu);
		rq.weight_v     = WEIGHT_W'(wv);
		send_request(rq);
	endtask

	// Writes all four block limits back to back; the write enable only drops after
	// the last one so that it never falls and rises within one time step.
	task automatic write_limits(logic [MAX_BLOCKS-1:0][ACC_W-1:0] lim);
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			cfg_we    <= 1'b1;
			cfg_idx   <= 2'(i);
			cfg_wdata <= lim[i];
			@(posedge clk);
			board.set_limit(i, lim[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Withdraws the request channel and waits for every outstanding result. Every
	// request yields exactly one result, so the block is idle once the queue is empty.
	task automatic drain();
		items_ch.valid <= 1'b0;
		while (board.awaited_outcomes.size() != 0) @(posedge clk);
	endtask

	function automatic logic [NODE_W-1:0] pick_node();
		if ($urandom_range(9) == 0)
			return NODE_W'($urandom_range(NODE_COUNT - 1));
		return NODE_W'(pool_base + int'($urandom_range(POOL_SPAN - 1)));
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return WEIGHT_W'($urandom_range(1500));
		if (roll < 85)
			return WEIGHT_W'($urandom);
		return $urandom_range(1) ? '1 : '0;
	endfunction

	function automatic pin_request_t random_request();
		pin_request_t rq;
		int           roll;
		roll            = $urandom_range(99);
		rq.node_u       = pick_node();
		rq.node_v       = pick_node();
		rq.target_block = BLOCK_W'($urandom_range(MAX_BLOCKS - 1));
		rq.weight_u     = pick_weight();
		rq.weight_v     = pick_weight();
		if (roll < 12) begin
			// Noise: every field fully random, nodes over the whole table.
			rq.mode     = mode_t'($urandom_range(3));
			rq.node_u   = NODE_W'($urandom_range(NODE_COUNT - 1));
			rq.node_v   = NODE_W'($urandom_range(NODE_COUNT - 1));
			rq.weight_u = WEIGHT_W'($urandom);
			rq.weight_v = WEIGHT_W'($urandom);
		end else if (roll < 35) begin
			rq.mode = MODE_FIX;
		end else if (roll < 70) begin
			rq.mode = ($urandom_range(3) == 0) ? MODE_CONTRACT_NC : MODE_CONTRACT;
			merge_log.push_back({rq.node_u, rq.node_v});
		end else begin
			rq.mode = MODE_UNCONTRACT;
			if (merge_log.size() != 0 && $urandom_range(3) != 0)
				{rq.node_u, rq.node_v} = merge_log.pop_back();
		end
		return rq;
	endfunction

	// Result side: checks each transfer, then picks the next ready value. A hold-off
	// is counted here, in cycles, while the request side keeps offering, so the
	// block backs up and stops taking requests.
	initial begin
		int            hold_left;
		step_outcome_t got;
		hold_left = 0;
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
				got.success            = results_ch.success;
				got.affected_block     = results_ch.affected_block;
				got.block_fixed_weight = results_ch.block_fixed_weight;
				got.total_fixed_weight = results_ch.total_fixed_weight;
				board.check_result(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				results_ch.ready <= 1'b0;
			end else if (stall_request) begin
				stall_request = 1'b0;
				hold_left = HOLD_CYCLES;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= no_idle || ($urandom_range(99) >= 15);
			end
		end
	end

	// Stimulus and the final verdict.
	initial begin
		logic [MAX_BLOCKS-1:0][ACC_W-1:0] lim;
		board         = new();
		no_idle       = 1'b0;
		stall_request = 1'b0;
		pool_base     = 0;
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_idx               <= '0;
		cfg_wdata             <= '0;
		items_ch.valid        <= 1'b0;
		items_ch.mode         <= MODE_FIX;
		items_ch.node_u       <= '0;
		items_ch.node_v       <= '0;
		items_ch.target_block <= '0;
		items_ch.weight_u     <= '0;
		items_ch.weight_v     <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// The limits may be written while the node table is still being cleared.
		// Block 1 gets a small limit and block 2 none at all, for the refusals below.
		lim[0] = LIMIT_MAX;
		lim[1] = ACC_W'(1000);
		lim[2] = '0;
		lim[3] = LIMIT_MAX;
		write_limits(lim);

		// Fixing: a fresh pin, the same pin again, a conflicting pin, the top node.
		issue(MODE_FIX, 0, 0, 0, 16'hFFFF, 0);
		issue(MODE_FIX, 0, 0, 0, 1, 1);
		issue(MODE_FIX, 0, 0, 3, 1, 1);
		issue(MODE_FIX, 1023, 1023, 3, 0, 16'hFFFF);
		// Merging: neither pinned, pin spreading to u, pin spreading to v, merge without
		// chains, pins in different blocks, and both in the same block.
		issue(MODE_CONTRACT, 5, 6, 0, 10, 10);
		issue(MODE_CONTRACT, 7, 0, 0, 100, 50);
		issue(MODE_CONTRACT, 0, 8, 0, 50, 200);
		issue(MODE_CONTRACT_NC, 0, 9, 0, 50, 300);
		issue(MODE_CONTRACT, 0, 1023, 0, 7, 7);
		issue(MODE_CONTRACT, 0, 7, 0, 7, 7);
		// Undoing: v not pinned, a counted merge, v pinned with no count of its own,
		// the last merge of a node, and a count that wraps below zero.
		issue(MODE_UNCONTRACT, 5, 6, 0, 0, 0);
		issue(MODE_UNCONTRACT, 0, 7, 0, 0, 0);
		issue(MODE_UNCONTRACT, 8, 8, 0, 0, 0);
		issue(MODE_UNCONTRACT, 7, 7, 0, 0, 0);
		issue(MODE_UNCONTRACT, 40, 1023, 0, 0, 0);
		// Limits: over the limit, exactly at it, and a block whose limit is zero.
		issue(MODE_FIX, 10, 0, 1, 900, 0);
		issue(MODE_CONTRACT, 11, 10, 0, 200, 0);
		issue(MODE_CONTRACT, 10, 12, 0, 0, 100);
		issue(MODE_FIX, 20, 0, 2, 5, 0);
		issue(MODE_CONTRACT, 21, 20, 0, 0, 0);
		issue(MODE_CONTRACT, 20, 22, 0, 0, 0);
		// Full weight carried across a merge.
		issue(MODE_FIX, 30, 0, 3, 0, 0);
		issue(MODE_CONTRACT, 30, 31, 0, 16'hFFFF, 16'hFFFF);

		// Random phases, each under its own set of limits. The second phase runs with
		// no gaps on either side; the others start with a long result hold-off.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			drain();
			case (phase)
				0: begin
					for (int b = 0; b < MAX_BLOCKS; b++) lim[b] = LIMIT_MAX;
				end
				1: begin
					for (int b = 0; b < MAX_BLOCKS; b++)
						lim[b] = ACC_W'($urandom_range(400000, 50000));
				end
				2: begin
					lim[0] = '0;
					lim[1] = LIMIT_MAX;
					lim[2] = ACC_W'($urandom_range(5000));
					lim[3] = ACC_W'($urandom);
				end
				default: begin
					for (int b = 0; b < MAX_BLOCKS; b++)
						lim[b] = ACC_W'($urandom_range(LIMIT_MAX));
				end
			endcase
			write_limits(lim);
			pool_base     = 64 + phase * 160;
			no_idle       = (phase == 1);
			stall_request = (phase != 1);
			merge_log.delete();
			repeat (PHASE_ITEMS) send_request(random_request());
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.failures == 0 && board.awaited_outcomes.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run including the clearing pass.
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
